>>> rtl/hsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types and constants for the saturation adjust pipeline.
// ----------------------------------------------------------------------------
package hsa_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned GAIN_W   = 12;
	localparam int unsigned PROD_W   = CHAN_W + GAIN_W;
	localparam int unsigned QUOT_W   = 8;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
	localparam int unsigned DIV_BITS_PER_STAGE = 2;

	// hue sectors, red to yellow through magenta to red
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} result_t;

	// analysis stage record
	typedef struct packed {
		logic       valid;
		logic       grey;
		logic [2:0] sector;
		logic [7:0] vmax;
		logic [7:0] delta;
		logic [7:0] num;
		logic [7:0] alpha;
	} front_t;

	// record carried through the divider stages
	typedef struct packed {
		logic       valid;
		logic       grey;
		logic       clamp;
		logic [2:0] sector;
		logic [7:0] vmax;
		logic [7:0] delta;
		logic [7:0] alpha;
		logic [7:0] rem_f;
		logic [7:0] rem_s;
		logic [7:0] bits_s;
		logic [QUOT_W-1:0] q_f;
		logic [QUOT_W-1:0] q_s;
	} div_t;

endpackage

>>> rtl/hsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_front
// Max/min, hue sector and the saturation product; two register stages.
// ----------------------------------------------------------------------------
module hsa_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  hsa_pkg::pixel_t          pixel,
	input  logic [hsa_pkg::GAIN_W-1:0] scale,
	output hsa_pkg::div_t            div_s2
);
	import hsa_pkg::*;

	logic [7:0] r, g, b, vmax, vmin, delta, num;
	logic [2:0] sector;
	front_t     front_s1;
	logic [PROD_W-1:0] prod;

	always_comb begin
		r = pixel.red_in;
		g = pixel.green_in;
		b = pixel.blue_in;
		vmax = r;
		vmin = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		delta = vmax - vmin;
		if (vmax == r) begin
			if (g >= b) begin
				sector = SEC_RY; num = g - b;
			end else begin
				sector = SEC_MR; num = delta - (b - g);
			end
		end else if (vmax == g) begin
			if (b >= r) begin
				sector = SEC_GC; num = b - r;
			end else begin
				sector = SEC_YG; num = delta - (r - b);
			end
		end else begin
			if (r >= g) begin
				sector = SEC_BM; num = r - g;
			end else begin
				sector = SEC_CB; num = delta - (g - r);
			end
		end
		// end of a sector is the start of the next
		if (num >= delta) begin
			num = 8'd0;
			unique case (sector)
				SEC_RY:  sector = SEC_YG;
				SEC_YG:  sector = SEC_GC;
				SEC_GC:  sector = SEC_CB;
				SEC_CB:  sector = SEC_BM;
				SEC_BM:  sector = SEC_MR;
				default: sector = SEC_RY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else begin
			front_s1.valid  <= start;
			front_s1.grey   <= (delta == 8'd0);
			front_s1.sector <= sector;
			front_s1.vmax   <= vmax;
			front_s1.delta  <= delta;
			front_s1.num    <= num;
			front_s1.alpha  <= pixel.alpha_in;
		end
	end

	assign prod = PROD_W'(front_s1.delta) * PROD_W'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s2 <= '0;
		end else begin
			div_s2.valid  <= front_s1.valid;
			div_s2.grey   <= front_s1.grey;
			div_s2.clamp  <= prod >= {{(PROD_W-16){1'b0}}, front_s1.vmax, 8'd0};
			div_s2.sector <= front_s1.sector;
			div_s2.vmax   <= front_s1.vmax;
			div_s2.delta  <= front_s1.delta;
			div_s2.alpha  <= front_s1.alpha;
			div_s2.rem_f  <= front_s1.num;
			div_s2.rem_s  <= prod[15:8];
			div_s2.bits_s <= prod[7:0];
			div_s2.q_f    <= '0;
			div_s2.q_s    <= '0;
		end
	end

endmodule

>>> rtl/hsa_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_div_stage
// A few restoring division steps for hue fraction and saturation at once.
// ----------------------------------------------------------------------------
module hsa_div_stage #(
	parameter int unsigned STEPS = hsa_pkg::DIV_BITS_PER_STAGE
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hsa_pkg::div_t d_in,
	output hsa_pkg::div_t d_out
);
	import hsa_pkg::*;

	div_t       nxt;
	logic [8:0] tf, ts;

	always_comb begin
		nxt = d_in;
		for (int i = 0; i < STEPS; i++) begin
			tf = {nxt.rem_f, 1'b0};
			ts = {nxt.rem_s, nxt.bits_s[7]};
			nxt.bits_s = {nxt.bits_s[6:0], 1'b0};
			if (tf >= {1'b0, nxt.delta}) begin
				tf = tf - {1'b0, nxt.delta};
				nxt.q_f = {nxt.q_f[QUOT_W-2:0], 1'b1};
			end else begin
				nxt.q_f = {nxt.q_f[QUOT_W-2:0], 1'b0};
			end
			if (ts >= {1'b0, nxt.vmax}) begin
				ts = ts - {1'b0, nxt.vmax};
				nxt.q_s = {nxt.q_s[QUOT_W-2:0], 1'b1};
			end else begin
				nxt.q_s = {nxt.q_s[QUOT_W-2:0], 1'b0};
			end
			nxt.rem_f = tf[7:0];
			nxt.rem_s = ts[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else begin
			d_out.valid  <= d_in.valid;
			d_out.grey   <= nxt.grey;
			d_out.clamp  <= nxt.clamp;
			d_out.sector <= nxt.sector;
			d_out.vmax   <= nxt.vmax;
			d_out.delta  <= nxt.delta;
			d_out.alpha  <= nxt.alpha;
			d_out.rem_f  <= nxt.rem_f;
			d_out.rem_s  <= nxt.rem_s;
			d_out.bits_s <= nxt.bits_s;
			d_out.q_f    <= nxt.q_f;
			d_out.q_s    <= nxt.q_s;
		end
	end

endmodule

>>> rtl/hsa_rebuild.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_rebuild
// Chroma, offset and second channel, then sector mapping to RGB.
// ----------------------------------------------------------------------------
module hsa_rebuild (
	input  logic             clk,
	input  logic             arst_n,
	input  hsa_pkg::div_t    d_in,
	output logic             done,
	output hsa_pkg::result_t result
);
	import hsa_pkg::*;

	logic [8:0]  sat, fsel;
	logic [16:0] chroma_full;
	logic        valid_s7, grey_s7;
	logic [2:0]  sector_s7;
	logic [7:0]  vmax_s7, alpha_s7;
	logic [15:0] chroma_s7, offset_s7;
	logic [8:0]  fsel_s7;
	logic [24:0] sec_prod;
	logic [16:0] mid_sum;
	logic [7:0]  hi, mid, lo;
	result_t     res;

	always_comb begin
		sat = d_in.clamp ? 9'd256 : {1'b0, d_in.q_s};
		fsel = d_in.sector[0] ? (9'd256 - {1'b0, d_in.q_f}) : {1'b0, d_in.q_f};
		chroma_full = 17'(d_in.vmax) * 17'(sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s7 <= d_in.valid;
			done     <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		grey_s7   <= d_in.grey;
		sector_s7 <= d_in.sector;
		vmax_s7   <= d_in.vmax;
		alpha_s7  <= d_in.alpha;
		chroma_s7 <= chroma_full[15:0];
		offset_s7 <= {d_in.vmax, 8'd0} - chroma_full[15:0];
		fsel_s7   <= fsel;
	end

	always_comb begin
		sec_prod = 25'(chroma_s7) * 25'(fsel_s7);
		mid_sum  = 17'(sec_prod[23:8]) + 17'(offset_s7);
		hi  = vmax_s7;
		mid = mid_sum[15:8];
		lo  = offset_s7[15:8];
		res.alpha_out = alpha_s7;
		unique case (sector_s7)
			SEC_RY: begin
				res.red_out = hi;  res.green_out = mid; res.blue_out = lo;
			end
			SEC_YG: begin
				res.red_out = mid; res.green_out = hi;  res.blue_out = lo;
			end
			SEC_GC: begin
				res.red_out = lo;  res.green_out = hi;  res.blue_out = mid;
			end
			SEC_CB: begin
				res.red_out = lo;  res.green_out = mid; res.blue_out = hi;
			end
			SEC_BM: begin
				res.red_out = mid; res.green_out = lo;  res.blue_out = hi;
			end
			default: begin
				res.red_out = hi;  res.green_out = lo;  res.blue_out = mid;
			end
		endcase
		if (grey_s7) begin
			res.red_out   = vmax_s7;
			res.green_out = vmax_s7;
			res.blue_out  = vmax_s7;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

endmodule

>>> rtl/hsv_saturation_adjust_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_saturation_adjust_top
// Saturation gain on RGBA8 pixels through an HSV round trip.
// ----------------------------------------------------------------------------
// usage
//   pixel in: drive pixel and raise start; a transfer happens at each edge
//   with start high and busy low. busy is always low, so one pixel can be
//   sent every clock.
//   result out: done is high for exactly one cycle with result valid; the
//   receiver must take it then, there is no backpressure.
//   gain: cfg_data (unsigned Q4.8, 256 = 1.0) is written on a cfg_valid /
//   cfg_ready transfer; cfg_ready is always high. write it only while no
//   pixel is in flight.
//   pipeline: an input transfer passes the front register stages, then the
//   two quotient pipelines (hue fraction and saturation), which resolve
//   BITS_PER_STAGE quotient bits per stage, then the rebuild registers to
//   done; throughput one pixel per clock.
//   reset: arst_n low clears all stage valid bits and sets the gain to 1.0;
//   nothing comes out until new pixels are sent.
// ----------------------------------------------------------------------------
module hsv_saturation_adjust_top #(
	parameter int unsigned BITS_PER_STAGE = hsa_pkg::DIV_BITS_PER_STAGE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  hsa_pkg::pixel_t             pixel,
	output logic                        done,
	output hsa_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hsa_pkg::GAIN_W-1:0]  cfg_data
);
	import hsa_pkg::*;

	localparam int unsigned DIV_STAGES = QUOT_W / BITS_PER_STAGE;
	localparam int unsigned LATENCY    = DIV_STAGES + 4;

	logic [GAIN_W-1:0] scale_q;
	div_t              div_pipe [DIV_STAGES+1];

	// pipeline never stalls, config always taken
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// max/min, sector, gain product
	hsa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.pixel  (pixel),
		.scale  (scale_q),
		.div_s2 (div_pipe[0])
	);

	// quotient pipeline, both divisions side by side
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		hsa_div_stage #(
			.STEPS (BITS_PER_STAGE)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.d_in   (div_pipe[k]),
			.d_out  (div_pipe[k+1])
		);
	end

	// back to rgb
	hsa_rebuild u_rebuild (
		.clk    (clk),
		.arst_n (arst_n),
		.d_in   (div_pipe[DIV_STAGES]),
		.done   (done),
		.result (result)
	);

	// every accepted pixel comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel did not come out");

	// no result without a matching input transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without input transfer");

	// alpha passes straight through
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY (result.alpha_out == $past(pixel.alpha_in, LATENCY)))
		else $error("alpha changed");

	// grey stays grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(start && pixel.red_in == pixel.green_in && pixel.green_in == pixel.blue_in)
		|-> ##LATENCY (result.red_out == result.green_out
			&& result.green_out == result.blue_out))
		else $error("grey pixel gained color");

endmodule
